// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VDM_ASSERT_IMPL(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
    else $error("vdm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VDM_ASSERT_NEXT(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
    else $error("vdm assertion failed");

`endif

// File: hw/rtl/vdm_pkg.sv
// ----------------------------------------------------------------------------
// vdm_pkg
// Shared widths, codes and controller/datapath interface types for the
// vector distance metrics block.
// ----------------------------------------------------------------------------
`default_nettype none

package vdm_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned MAX_LENGTH = 1024;
  localparam int unsigned LEN_RESET  = 602;
  localparam int unsigned SQD_W      = 43;
  localparam int unsigned ABD_W      = 27;
  localparam int unsigned CUBE_W     = 59;
  localparam int unsigned SQ_W       = 41;
  localparam int unsigned VIDX_W     = 32;

  // Shared iterative units.
  localparam int unsigned RAD_W  = 44;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned NUM_W  = 57;
  localparam int unsigned DEN_W  = 42;
  localparam int unsigned CBX_W  = 60;
  localparam int unsigned CBY_W  = CBX_W / 3;

  localparam int unsigned COS_ONE = 65536;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_CUBE, ST_ACCUM,
    ST_F1_GO, ST_F1_WAIT, ST_F2_GO, ST_F2_WAIT,
    ST_F3_GO, ST_F3_WAIT, ST_DEN, ST_F5_GO, ST_F5_WAIT, ST_PUBLISH
  } ctrl_state_e;

  typedef enum logic [1:0] {SQ_DIFF, SQ_FIRST, SQ_SECOND} sqrt_sel_e;
  typedef enum logic [1:0] {DIV_MSE, DIV_MAE, DIV_COS} div_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      do_prod;
    logic      do_cube;
    logic      do_acc;
    logic      sqrt_start;
    sqrt_sel_e sqrt_sel;
    logic      div_start;
    div_sel_e  div_sel;
    logic      cbrt_start;
    logic      cap1;
    logic      cap2;
    logic      cap3;
    logic      do_den;
    logic      cap5;
    logic      publish;
  } vdm_cmd_t;

  typedef struct packed {
    logic last;
    logic busy;
    logic zero_norm;
    logic out_busy;
  } vdm_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/vdm_isqrt.sv
// ----------------------------------------------------------------------------
// vdm_isqrt
// Floor square root, two radicand bits per cycle (restoring digit method).
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_isqrt
  import vdm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  output logic                   busy_o,
  output logic [ROOT_W-1:0]      root_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  x_q;
  logic [ROOT_W+1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;

  // Bring in the next two radicand bits and form the trial subtrahend.
  assign rem_sh = {rem_q[ROOT_W-1:0], x_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(ROOT_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q <= {x_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: hw/rtl/vdm_div.sv
// ----------------------------------------------------------------------------
// vdm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_div
  import vdm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sub[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/vdm_ctrl.sv
// ----------------------------------------------------------------------------
// vdm_ctrl
// Sequencer: steps each element word through the product, cube and accumulate
// stages, then after the last word runs the end-of-vector root and divide passes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vdm_ctrl
  import vdm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire vdm_stat_t stat_i,
  output vdm_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.do_prod = 1'b1;
        state_d       = ST_CUBE;
      end
      ST_CUBE: begin
        cmd_o.do_cube = 1'b1;
        state_d       = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.do_acc = 1'b1;
        state_d      = stat_i.last ? ST_F1_GO : ST_IDLE;
      end
      ST_F1_GO: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.sqrt_sel   = SQ_DIFF;
        cmd_o.div_start  = 1'b1;
        cmd_o.div_sel    = DIV_MSE;
        cmd_o.cbrt_start = 1'b1;
        state_d          = ST_F1_WAIT;
      end
      ST_F1_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.cap1 = 1'b1;
          state_d    = ST_F2_GO;
        end
      end
      ST_F2_GO: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.sqrt_sel   = SQ_FIRST;
        cmd_o.div_start  = 1'b1;
        cmd_o.div_sel    = DIV_MAE;
        state_d          = ST_F2_WAIT;
      end
      ST_F2_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.cap2 = 1'b1;
          state_d    = ST_F3_GO;
        end
      end
      ST_F3_GO: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.sqrt_sel   = SQ_SECOND;
        state_d          = ST_F3_WAIT;
      end
      ST_F3_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.cap3 = 1'b1;
          state_d    = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd_o.do_den = 1'b1;
        state_d      = ST_F5_GO;
      end
      ST_F5_GO: begin
        // A zero norm leaves the cosine at zero and skips the divide.
        if (stat_i.zero_norm) begin
          state_d = ST_PUBLISH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_COS;
          state_d         = ST_F5_WAIT;
        end
      end
      ST_F5_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.cap5 = 1'b1;
          state_d    = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The units must be idle whenever a pass is launched.
  `VDM_ASSERT_IMPL(a_go_idle, clk_i, rst_ni, (state_q == ST_F1_GO || state_q == ST_F2_GO || state_q == ST_F3_GO || state_q == ST_F5_GO), !stat_i.busy)
  // A result is never published over one that is still waiting.
  `VDM_ASSERT_IMPL(a_pub_free, clk_i, rst_ni, cmd_o.publish, !stat_i.out_busy)
  // The last element of a vector always starts the end-of-vector passes.
  `VDM_ASSERT_NEXT(a_last_fin, clk_i, rst_ni, (state_q == ST_ACCUM && stat_i.last), state_q == ST_F1_GO)

endmodule

`default_nettype wire

// File: hw/rtl/vdm_dp.sv
// ----------------------------------------------------------------------------
// vdm_dp
// Datapath: element products, running sums, shared root and divide units,
// the cube-root unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vdm_dp
  import vdm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire vdm_cmd_t                cmd_i,
  output vdm_stat_t                    stat_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [LEN_W-1:0]        cfg_data_i,
  input  wire logic signed [DATA_W-1:0] value_a_i,
  input  wire logic signed [DATA_W-1:0] value_b_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [33:0]                  mean_sq_error_o,
  output logic [16:0]                  mean_abs_error_o,
  output logic [21:0]                  euclid_distance_o,
  output logic [20:0]                  minkowski3_distance_o,
  output logic [16:0]                  abs_cosine_o,
  output logic                         zero_norm_o,
  output logic [VIDX_W-1:0]            vector_index_o
);

  // Configuration and effective length.
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] count_q;
  logic             last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(LEN_RESET);
    end else if (cfg_we_i) begin
      len_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_LENGTH)) begin
      len_eff = LEN_W'(MAX_LENGTH);
    end else begin
      len_eff = len_q;
    end
  end

  assign last = ({1'b0, count_q} + 1'b1) >= {1'b0, len_eff};

  // Input word and per-element products.
  logic signed [DATA_W-1:0] a_q, b_q;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          diff_mag, a_mag, b_mag;
  logic [DATA_W-1:0]        ad_q;
  logic [31:0]              d2_q;
  logic [30:0]              sa_q, sb_q, pab_q;
  logic [47:0]              cube_q;
  logic [33:0]              sa_full, sb_full, pab_full;
  logic [31:0]              d2_full;

  assign diff     = {a_q[DATA_W-1], a_q} - {b_q[DATA_W-1], b_q};
  assign diff_mag = diff[DATA_W] ? (~diff + 1'b1) : diff;
  assign a_mag    = a_q[DATA_W-1] ? (~{1'b1, a_q} + 1'b1) : {1'b0, a_q};
  assign b_mag    = b_q[DATA_W-1] ? (~{1'b1, b_q} + 1'b1) : {1'b0, b_q};
  assign d2_full  = diff_mag[DATA_W-1:0] * diff_mag[DATA_W-1:0];
  assign sa_full  = a_mag * a_mag;
  assign sb_full  = b_mag * b_mag;
  assign pab_full = a_mag * b_mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      a_q <= value_a_i;
      b_q <= value_b_i;
    end
    if (cmd_i.do_prod) begin
      ad_q  <= diff_mag[DATA_W-1:0];
      d2_q  <= d2_full;
      sa_q  <= sa_full[30:0];
      sb_q  <= sb_full[30:0];
      pab_q <= pab_full[30:0];
    end
    if (cmd_i.do_cube) begin
      cube_q <= d2_q * ad_q;
    end
  end

  // Running sums; each wraps at its width.
  logic [SQD_W-1:0]  sqd_q;
  logic [ABD_W-1:0]  abd_q;
  logic [CUBE_W-1:0] cub_q;
  logic [SQ_W-1:0]   sqa_q, sqb_q, prd_q;
  logic [VIDX_W-1:0] vdone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqd_q   <= '0;
      abd_q   <= '0;
      cub_q   <= '0;
      sqa_q   <= '0;
      sqb_q   <= '0;
      prd_q   <= '0;
      count_q <= '0;
      vdone_q <= '0;
    end else begin
      if (cmd_i.do_cube) begin
        sqd_q <= sqd_q + SQD_W'(d2_q);
        abd_q <= abd_q + ABD_W'(ad_q);
        sqa_q <= sqa_q + SQ_W'(sa_q);
        sqb_q <= sqb_q + SQ_W'(sb_q);
        prd_q <= prd_q + SQ_W'(pab_q);
      end
      if (cmd_i.do_acc) begin
        cub_q   <= cub_q + CUBE_W'(cube_q);
        count_q <= last ? '0 : count_q + 1'b1;
      end
      if (cmd_i.publish) begin
        sqd_q   <= '0;
        abd_q   <= '0;
        cub_q   <= '0;
        sqa_q   <= '0;
        sqb_q   <= '0;
        prd_q   <= '0;
        vdone_q <= vdone_q + 1'b1;
      end
    end
  end

  // Shared square root and divider operand selection.
  logic [RAD_W-1:0]  rad;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  den_q;
  logic              sqrt_busy, div_busy;
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  quo;

  always_comb begin
    case (cmd_i.sqrt_sel)
      SQ_DIFF:   rad = RAD_W'(sqd_q);
      SQ_FIRST:  rad = RAD_W'(sqa_q);
      SQ_SECOND: rad = RAD_W'(sqb_q);
      default:   rad = '0;
    endcase
    case (cmd_i.div_sel)
      DIV_MSE: begin
        num = NUM_W'(sqd_q);
        den = DEN_W'(len_eff);
      end
      DIV_MAE: begin
        num = NUM_W'(abd_q);
        den = DEN_W'(len_eff);
      end
      DIV_COS: begin
        num = {prd_q, 16'h0000};
        den = den_q;
      end
      default: begin
        num = '0;
        den = DEN_W'(1);
      end
    endcase
  end

  vdm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (rad),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  vdm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Cube root: three bits per step, each step split into a trial phase
  // (multiply) and a compare phase.
  logic             cb_busy_q;
  logic             cb_phase_q;
  logic [4:0]       cb_cnt_q;
  logic [CBX_W-1:0] cb_x_q;
  logic [45:0]      cb_r_q;
  logic [CBY_W-1:0] cb_y_q;
  logic [42:0]      cb_b_q;
  logic [CBY_W-1:0] cb_y2;
  logic [40:0]      cb_yy;

  assign cb_y2 = {cb_y_q[CBY_W-2:0], 1'b0};
  assign cb_yy = cb_y2 * ({1'b0, cb_y2} + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_busy_q  <= 1'b0;
      cb_phase_q <= 1'b0;
      cb_cnt_q   <= '0;
    end else if (cmd_i.cbrt_start) begin
      cb_busy_q  <= 1'b1;
      cb_phase_q <= 1'b0;
      cb_cnt_q   <= 5'(CBY_W);
    end else if (cb_busy_q) begin
      cb_phase_q <= ~cb_phase_q;
      if (cb_phase_q) begin
        cb_cnt_q <= cb_cnt_q - 1'b1;
        if (cb_cnt_q == 5'd1) begin
          cb_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cbrt_start) begin
      cb_x_q <= CBX_W'(cub_q);
      cb_r_q <= '0;
      cb_y_q <= '0;
    end else if (cb_busy_q) begin
      if (!cb_phase_q) begin
        cb_r_q <= {cb_r_q[42:0], cb_x_q[CBX_W-1 -: 3]};
        cb_x_q <= {cb_x_q[CBX_W-4:0], 3'b000};
        cb_y_q <= cb_y2;
        cb_b_q <= {1'b0, cb_yy, 1'b0} + 43'(cb_yy) + 1'b1;
      end else if (cb_r_q >= 46'(cb_b_q)) begin
        cb_r_q <= cb_r_q - 46'(cb_b_q);
        cb_y_q <= cb_y_q | CBY_W'(1);
      end
    end
  end

  // Captured results.
  logic [33:0]   mse_q;
  logic [16:0]   mae_q;
  logic [21:0]   euc_q;
  logic [20:0]   mink_q;
  logic [16:0]   cos_q;
  logic [20:0]   na_q, nb_q;
  logic          zn;

  assign zn = (na_q == '0) || (nb_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap1) begin
      euc_q  <= root;
      mse_q  <= quo[33:0];
      mink_q <= 21'(cb_y_q);
    end
    if (cmd_i.cap2) begin
      na_q  <= root[20:0];
      mae_q <= quo[16:0];
    end
    if (cmd_i.cap3) begin
      nb_q <= root[20:0];
    end
    if (cmd_i.do_den) begin
      den_q <= na_q * nb_q;
      cos_q <= '0;
    end
    if (cmd_i.cap5) begin
      cos_q <= (quo > NUM_W'(COS_ONE)) ? 17'(COS_ONE) : quo[16:0];
    end
  end

  // Result register: holds one finished vector until it is taken.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      mean_sq_error_o       <= mse_q;
      mean_abs_error_o      <= mae_q;
      euclid_distance_o     <= euc_q;
      minkowski3_distance_o <= mink_q;
      abs_cosine_o          <= cos_q;
      zero_norm_o           <= zn;
      vector_index_o        <= vdone_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.last      = last;
  assign stat_o.busy      = sqrt_busy | div_busy | cb_busy_q;
  assign stat_o.zero_norm = zn;
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

endmodule

`default_nettype wire

// File: hw/rtl/vector_distance_metrics.sv
// Each element word passes through four steps (accept, products, cube, accumulate).
// The last word of a vector then starts the end-of-vector passes, which
// run the shared divider up to three times (twice on a zero norm).
// Results wait in an output register; a new element word is taken meanwhile.
// Reset clears all sums and counts and sets the vector length to 602.
// ----------------------------------------------------------------------------
// vector_distance_metrics
// Streams pairs of Q4.12 elements and reports per-vector distance metrics.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_distance_metrics
  import vdm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [LEN_W-1:0]         cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [DATA_W-1:0] value_a_i,
  input  wire logic signed [DATA_W-1:0] value_b_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [33:0]                   mean_sq_error_o,
  output logic [16:0]                   mean_abs_error_o,
  output logic [21:0]                   euclid_distance_o,
  output logic [20:0]                   minkowski3_distance_o,
  output logic [16:0]                   abs_cosine_o,
  output logic                          zero_norm_o,
  output logic [VIDX_W-1:0]             vector_index_o
);

  vdm_cmd_t  cmd;
  vdm_stat_t stat;

  // Sequencer.
  vdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and result storage.
  vdm_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cfg_we_i              (cfg_we_i),
    .cfg_data_i            (cfg_data_i),
    .value_a_i             (value_a_i),
    .value_b_i             (value_b_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .mean_sq_error_o       (mean_sq_error_o),
    .mean_abs_error_o      (mean_abs_error_o),
    .euclid_distance_o     (euclid_distance_o),
    .minkowski3_distance_o (minkowski3_distance_o),
    .abs_cosine_o          (abs_cosine_o),
    .zero_norm_o           (zero_norm_o),
    .vector_index_o        (vector_index_o)
  );

endmodule

`default_nettype wire
